>>> design/lorentz_boost_four_vector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-vector boost block
// Implication checks on the same and on the next clock edge.
// ----------------------------------------------------------------------------
`ifndef LORENTZ_BOOST_FOUR_VECTOR_ASSERT_SVH
`define LORENTZ_BOOST_FOUR_VECTOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LBFV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// consequent must hold in the cycle after the antecedent
`define LBFV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> design/lbfv_pkg.sv
// ----------------------------------------------------------------------------
// lbfv_pkg
// Shared types for the four-vector boost pipeline.
// ----------------------------------------------------------------------------
package lbfv_pkg;

   // per-stage control handed to the pipelined units
   typedef struct packed {
      logic valid;
      logic en;
   } step_type;

endpackage

>>> design/lbfv_isqrt.sv
// ----------------------------------------------------------------------------
// lbfv_isqrt
// Pipelined integer square root, one result bit per stage (floor).
// ----------------------------------------------------------------------------
module lbfv_isqrt import lbfv_pkg::*; #(
   parameter int RW     = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  step_type          step_in,
   input  logic [2*RW-2:0]   rad_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output logic [RW-1:0]     root_out,
   output logic [SIDE_W-1:0] side_out
);

   localparam int RMW = 2*RW+1;

   logic [RMW-1:0]    rem_ff  [RW-1];
   logic [RW-1:0]     root_ff [RW];
   logic [SIDE_W-1:0] side_ff [RW];
   logic              vld_ff  [RW];

   genvar g;
   for (g = 0; g < RW; g++) begin : g_stage
      localparam int K = RW-1-g;
      logic [RMW-1:0]    rem_cur;
      logic [RMW-1:0]    trial;
      logic [RMW-1:0]    rem_in;
      logic [RW-1:0]     root_cur;
      logic [RW-1:0]     root_in;
      logic [SIDE_W-1:0] side_cur;
      logic              vld_cur;
      logic              fits;

      if (g == 0) begin : g_first
         assign rem_cur  = RMW'(rad_in);
         assign root_cur = '0;
         assign side_cur = side_in;
         assign vld_cur  = step_in.valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[g-1];
         assign root_cur = root_ff[g-1];
         assign side_cur = side_ff[g-1];
         assign vld_cur  = vld_ff[g-1];
      end

      // root bits so far sit above bit K, so the trial term is a plain OR
      always_comb begin
         trial   = (RMW'(root_cur) << (K+1)) | (RMW'(1) << (2*K));
         fits    = rem_cur >= trial;
         rem_in  = fits ? rem_cur - trial : rem_cur;
         root_in = fits ? (root_cur | (RW'(1) << K)) : root_cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (step_in.en) begin
            vld_ff[g] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (step_in.en) begin
            root_ff[g] <= root_in;
            side_ff[g] <= side_cur;
         end
      end

      if (g < RW-1) begin : g_rem
         always_ff @(posedge clock) begin
            if (step_in.en) begin
               rem_ff[g] <= rem_in;
            end
         end
      end
   end

   assign valid_out = vld_ff[RW-1];
   assign root_out  = root_ff[RW-1];
   assign side_out  = side_ff[RW-1];

endmodule

>>> design/lbfv_rdiv.sv
// ----------------------------------------------------------------------------
// lbfv_rdiv
// Pipelined restoring divider, one quotient bit per stage, then a
// round-half-up stage on the magnitude.
// ----------------------------------------------------------------------------
module lbfv_rdiv import lbfv_pkg::*; #(
   parameter int NUMW   = 98,
   parameter int DENW   = 64,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  step_type          step_in,
   input  logic [NUMW-1:0]   num_in,
   input  logic [DENW-1:0]   den_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output logic [NUMW:0]     quo_out,
   output logic [SIDE_W-1:0] side_out
);

   localparam int LAST = NUMW-1;

   logic [NUMW-1:0]   nq_ff   [NUMW];
   logic [DENW-1:0]   rem_ff  [NUMW];
   logic [DENW-1:0]   den_ff  [NUMW];
   logic [SIDE_W-1:0] side_ff [NUMW];
   logic              vld_ff  [NUMW];

   genvar g;
   for (g = 0; g < NUMW; g++) begin : g_stage
      logic [NUMW-1:0]   nq_cur;
      logic [NUMW-1:0]   nq_in;
      logic [DENW-1:0]   rem_cur;
      logic [DENW-1:0]   rem_in;
      logic [DENW-1:0]   den_cur;
      logic [DENW:0]     rem_sh;
      logic [DENW:0]     diff;
      logic [SIDE_W-1:0] side_cur;
      logic              vld_cur;
      logic              fits;

      if (g == 0) begin : g_first
         assign nq_cur   = num_in;
         assign rem_cur  = '0;
         assign den_cur  = den_in;
         assign side_cur = side_in;
         assign vld_cur  = step_in.valid;
      end else begin : g_next
         assign nq_cur   = nq_ff[g-1];
         assign rem_cur  = rem_ff[g-1];
         assign den_cur  = den_ff[g-1];
         assign side_cur = side_ff[g-1];
         assign vld_cur  = vld_ff[g-1];
      end

      // numerator bits leave at the top, quotient bits enter at the bottom
      always_comb begin
         rem_sh = {rem_cur, nq_cur[NUMW-1]};
         diff   = rem_sh - {1'b0, den_cur};
         fits   = rem_sh >= {1'b0, den_cur};
         rem_in = fits ? diff[DENW-1:0] : rem_sh[DENW-1:0];
         nq_in  = {nq_cur[NUMW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (step_in.en) begin
            vld_ff[g] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (step_in.en) begin
            nq_ff[g]   <= nq_in;
            rem_ff[g]  <= rem_in;
            den_ff[g]  <= den_cur;
            side_ff[g] <= side_cur;
         end
      end
   end

   logic              round_up;
   logic [NUMW:0]     quo_in;
   logic [NUMW:0]     quo_ff;
   logic [SIDE_W-1:0] side_o_ff;
   logic              vld_o_ff;

   // round to nearest, ties up: 2r >= d
   always_comb begin
      round_up = {rem_ff[LAST], 1'b0} >= {1'b0, den_ff[LAST]};
      quo_in   = (NUMW+1)'(nq_ff[LAST]) + (NUMW+1)'(round_up);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_o_ff <= 1'b0;
      end else if (step_in.en) begin
         vld_o_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (step_in.en) begin
         quo_ff    <= quo_in;
         side_o_ff <= side_ff[LAST];
      end
   end

   assign valid_out = vld_o_ff;
   assign quo_out   = quo_ff;
   assign side_out  = side_o_ff;

endmodule

>>> design/lorentz_boost_four_vector.sv
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector
// Built on a bit-per-stage square root (COMP_WIDTH stages) and a
// bit-per-stage restoring divider with a final rounding stage.
// Throughput: one transaction per cycle; a stalled result holds the whole pipe.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vector import lbfv_pkg::*; #(
   parameter int COMP_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COMP_WIDTH-1:0] req_part_px,
   input  logic signed [COMP_WIDTH-1:0] req_part_py,
   input  logic signed [COMP_WIDTH-1:0] req_part_pz,
   input  logic signed [COMP_WIDTH-1:0] req_part_e,
   input  logic signed [COMP_WIDTH-1:0] req_boost_px,
   input  logic signed [COMP_WIDTH-1:0] req_boost_py,
   input  logic signed [COMP_WIDTH-1:0] req_boost_pz,
   input  logic signed [COMP_WIDTH-1:0] req_boost_e,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COMP_WIDTH-1:0] rsp_out_px,
   output logic signed [COMP_WIDTH-1:0] rsp_out_py,
   output logic signed [COMP_WIDTH-1:0] rsp_out_pz,
   output logic signed [COMP_WIDTH-1:0] rsp_out_e,
   output logic                         rsp_not_timelike,
   output logic                         rsp_saturated
);

`include "lorentz_boost_four_vector_assert.svh"

   localparam int W     = COMP_WIDTH;
   localparam int PW    = 2*W;      // single products
   localparam int SW    = 2*W+2;    // dot, |a|^2, E*A - dot
   localparam int QW    = 2*W-1;    // radicand
   localparam int ESW   = 2*W+2;    // E*s
   localparam int SMW   = 2*W+3;    // s*m
   localparam int NSW   = 2*W+3;    // N = dot - E*s
   localparam int NMW   = 2*W+2;    // |N|
   localparam int HW    = NMW-W;    // upper slice of |N|
   localparam int HPW   = HW+W;     // upper partial product
   localparam int EMW   = 2*W+1;    // |E*A - dot|
   localparam int DW    = 2*W;      // divisor
   localparam int TW    = 3*W+2;    // dividend
   localparam int VW    = 3*W+5;    // signed result before clipping

   localparam logic signed [VW-1:0] VMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic [W-1:0]         WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]         WMIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [2:0][W-1:0]  p;
      logic [2:0][W-1:0]  a;
      logic [W-1:0]       e;
      logic [W-1:0]       ae;
      logic [2:0][PW-1:0] aa;
      logic [2:0][PW-1:0] pa;
      logic [PW-1:0]      ae2;
      logic [PW-1:0]      ea;
   } st1_type;

   typedef struct packed {
      logic [2:0][W-1:0] p;
      logic [2:0][W-1:0] a;
      logic [W-1:0]      e;
      logic [W-1:0]      ae;
      logic [SW-1:0]     asq;
      logic [SW-1:0]     dot;
      logic [PW-1:0]     ae2;
      logic [PW-1:0]     ea;
   } st2_type;

   typedef struct packed {
      logic              tl;
      logic [SW-1:0]     num;
      logic [SW-1:0]     dot;
      logic [2:0][W-1:0] p;
      logic [2:0][W-1:0] a;
      logic [W-1:0]      e;
      logic [W-1:0]      ae;
   } sq_side_type;

   typedef struct packed {
      logic [QW-1:0] rad;
      sq_side_type   side;
   } st3_type;

   typedef struct packed {
      logic [W+1:0]      s;
      logic [W-1:0]      m;
      logic              tl;
      logic [SW-1:0]     num;
      logic [SW-1:0]     dot;
      logic [2:0][W-1:0] p;
      logic [2:0][W-1:0] a;
      logic [W-1:0]      e;
   } st4_type;

   typedef struct packed {
      logic [ESW-1:0]    es;
      logic [SMW-1:0]    sm;
      logic              s_neg;
      logic              s_zero;
      logic [W-1:0]      m;
      logic              tl;
      logic [SW-1:0]     num;
      logic [SW-1:0]     dot;
      logic [2:0][W-1:0] p;
      logic [2:0][W-1:0] a;
   } st5_type;

   typedef struct packed {
      logic [NSW-1:0]    n;
      logic [DW-1:0]     d;
      logic              num_neg;
      logic [EMW-1:0]    num_mag;
      logic              s_neg;
      logic              s_zero;
      logic [W-1:0]      m;
      logic              tl;
      logic [2:0][W-1:0] p;
      logic [2:0][W-1:0] a;
   } st6_type;

   typedef struct packed {
      logic [NMW-1:0]    n_mag;
      logic              n_neg;
      logic [2:0][W-1:0] a_mag;
      logic [2:0]        a_neg;
      logic [DW-1:0]     d;
      logic              num_neg;
      logic [EMW-1:0]    num_mag;
      logic              s_neg;
      logic              s_zero;
      logic [W-1:0]      m;
      logic              tl;
      logic [2:0][W-1:0] p;
   } st7_type;

   typedef struct packed {
      logic [2:0][DW-1:0]  lo;
      logic [2:0][HPW-1:0] hi;
      logic [2:0]          neg;
      logic [DW-1:0]       d;
      logic                num_neg;
      logic [EMW-1:0]      num_mag;
      logic                s_zero;
      logic [W-1:0]        m;
      logic                tl;
      logic [2:0][W-1:0]   p;
   } st8_type;

   typedef struct packed {
      logic [2:0][TW-1:0] t;
      logic [2:0]         neg;
      logic [DW-1:0]      d;
      logic               num_neg;
      logic [EMW-1:0]     num_mag;
      logic               s_zero;
      logic [W-1:0]       m;
      logic               tl;
      logic [2:0][W-1:0]  p;
   } st9_type;

   typedef struct packed {
      logic [2:0]        neg;
      logic              num_neg;
      logic              s_zero;
      logic              tl;
      logic [2:0][W-1:0] p;
   } dv_side_type;

   typedef struct packed {
      logic [2:0][VW-1:0] v;
      logic [VW-1:0]      ve;
      logic               tl;
   } st10_type;

   typedef struct packed {
      logic [W-1:0] px;
      logic [W-1:0] py;
      logic [W-1:0] pz;
      logic [W-1:0] e;
      logic         nt;
      logic         sat;
   } rsp_type;

   logic        en;
   step_type    sq_step;
   step_type    dv_step;

   st1_type     st1_in, st1_ff;
   st2_type     st2_in, st2_ff;
   st3_type     st3_in, st3_ff;
   st4_type     st4_in, st4_ff;
   st5_type     st5_in, st5_ff;
   st6_type     st6_in, st6_ff;
   st7_type     st7_in, st7_ff;
   st8_type     st8_in, st8_ff;
   st9_type     st9_in, st9_ff;
   st10_type    st10_in, st10_ff;
   rsp_type     rsp_in, rsp_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic rsp_valid_ff;

   logic          sq_valid;
   logic [W-1:0]  sq_root;
   sq_side_type   sq_side;
   logic          dv_valid;
   dv_side_type   dv_side_in, dv_side;
   logic [TW:0]   q_p [3];
   logic [TW:0]   q_e;

   // whole pipe moves unless a finished result is waiting
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign sq_step   = '{valid: v3_ff, en: en};
   assign dv_step   = '{valid: v9_ff, en: en};

   // products
   always_comb begin
      st1_in.p[0] = req_part_px;
      st1_in.p[1] = req_part_py;
      st1_in.p[2] = req_part_pz;
      st1_in.a[0] = req_boost_px;
      st1_in.a[1] = req_boost_py;
      st1_in.a[2] = req_boost_pz;
      st1_in.e    = req_part_e;
      st1_in.ae   = req_boost_e;
      for (int i = 0; i < 3; i++) begin
         st1_in.aa[i] = PW'($signed(st1_in.a[i])) * PW'($signed(st1_in.a[i]));
         st1_in.pa[i] = PW'($signed(st1_in.p[i])) * PW'($signed(st1_in.a[i]));
      end
      st1_in.ae2 = PW'(req_boost_e) * PW'(req_boost_e);
      st1_in.ea  = PW'(req_part_e) * PW'(req_boost_e);
   end

   // sums of three
   always_comb begin
      st2_in.p   = st1_ff.p;
      st2_in.a   = st1_ff.a;
      st2_in.e   = st1_ff.e;
      st2_in.ae  = st1_ff.ae;
      st2_in.asq = SW'($signed(st1_ff.aa[0])) + SW'($signed(st1_ff.aa[1]))
                 + SW'($signed(st1_ff.aa[2]));
      st2_in.dot = SW'($signed(st1_ff.pa[0])) + SW'($signed(st1_ff.pa[1]))
                 + SW'($signed(st1_ff.pa[2]));
      st2_in.ae2 = st1_ff.ae2;
      st2_in.ea  = st1_ff.ea;
   end

   // mass squared and energy numerator
   always_comb begin
      logic signed [SW-1:0] m2;
      m2                = SW'($signed(st2_ff.ae2)) - $signed(st2_ff.asq);
      st3_in.rad        = m2[QW-1:0];
      st3_in.side.tl    = !m2[SW-1] && (m2 != '0);
      st3_in.side.num   = SW'($signed(st2_ff.ea)) - $signed(st2_ff.dot);
      st3_in.side.dot   = st2_ff.dot;
      st3_in.side.p     = st2_ff.p;
      st3_in.side.a     = st2_ff.a;
      st3_in.side.e     = st2_ff.e;
      st3_in.side.ae    = st2_ff.ae;
   end

   lbfv_isqrt #(
      .RW     (W),
      .SIDE_W ($bits(sq_side_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .step_in   (sq_step),
      .rad_in    (st3_ff.rad),
      .side_in   (st3_ff.side),
      .valid_out (sq_valid),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   // s = A + m
   always_comb begin
      st4_in.s   = (W+2)'($signed(sq_side.ae)) + (W+2)'({1'b0, sq_root});
      st4_in.m   = sq_root;
      st4_in.tl  = sq_side.tl;
      st4_in.num = sq_side.num;
      st4_in.dot = sq_side.dot;
      st4_in.p   = sq_side.p;
      st4_in.a   = sq_side.a;
      st4_in.e   = sq_side.e;
   end

   // E*s and s*m
   always_comb begin
      st5_in.es     = ESW'($signed(st4_ff.e)) * ESW'($signed(st4_ff.s));
      st5_in.sm     = SMW'($signed(st4_ff.s)) * SMW'($signed({1'b0, st4_ff.m}));
      st5_in.s_neg  = st4_ff.s[W+1];
      st5_in.s_zero = st4_ff.s == '0;
      st5_in.m      = st4_ff.m;
      st5_in.tl     = st4_ff.tl;
      st5_in.num    = st4_ff.num;
      st5_in.dot    = st4_ff.dot;
      st5_in.p      = st4_ff.p;
      st5_in.a      = st4_ff.a;
   end

   // N = p.a - E*(A+m), divisor |s|*m, |E*A - p.a|
   always_comb begin
      st6_in.n       = NSW'($signed(st5_ff.dot)) - NSW'($signed(st5_ff.es));
      st6_in.d       = DW'(st5_ff.sm[SMW-1] ? -st5_ff.sm : st5_ff.sm);
      st6_in.num_neg = st5_ff.num[SW-1];
      st6_in.num_mag = EMW'(st5_ff.num[SW-1] ? -st5_ff.num : st5_ff.num);
      st6_in.s_neg   = st5_ff.s_neg;
      st6_in.s_zero  = st5_ff.s_zero;
      st6_in.m       = st5_ff.m;
      st6_in.tl      = st5_ff.tl;
      st6_in.p       = st5_ff.p;
      st6_in.a       = st5_ff.a;
   end

   // magnitudes for the unsigned multiply
   always_comb begin
      st7_in.n_neg = st6_ff.n[NSW-1];
      st7_in.n_mag = NMW'(st6_ff.n[NSW-1] ? -st6_ff.n : st6_ff.n);
      for (int i = 0; i < 3; i++) begin
         st7_in.a_neg[i] = st6_ff.a[i][W-1];
         st7_in.a_mag[i] = st6_ff.a[i][W-1] ? -st6_ff.a[i] : st6_ff.a[i];
      end
      st7_in.d       = st6_ff.d;
      st7_in.num_neg = st6_ff.num_neg;
      st7_in.num_mag = st6_ff.num_mag;
      st7_in.s_neg   = st6_ff.s_neg;
      st7_in.s_zero  = st6_ff.s_zero;
      st7_in.m       = st6_ff.m;
      st7_in.tl      = st6_ff.tl;
      st7_in.p       = st6_ff.p;
   end

   // |N|*|a_i| as two partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         st8_in.lo[i]  = DW'(st7_ff.n_mag[W-1:0]) * DW'(st7_ff.a_mag[i]);
         st8_in.hi[i]  = HPW'(st7_ff.n_mag[NMW-1:W]) * HPW'(st7_ff.a_mag[i]);
         st8_in.neg[i] = st7_ff.n_neg ^ st7_ff.a_neg[i] ^ st7_ff.s_neg;
      end
      st8_in.d       = st7_ff.d;
      st8_in.num_neg = st7_ff.num_neg;
      st8_in.num_mag = st7_ff.num_mag;
      st8_in.s_zero  = st7_ff.s_zero;
      st8_in.m       = st7_ff.m;
      st8_in.tl      = st7_ff.tl;
      st8_in.p       = st7_ff.p;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         st9_in.t[i] = TW'(st8_ff.lo[i]) + (TW'(st8_ff.hi[i]) << W);
      end
      st9_in.neg     = st8_ff.neg;
      st9_in.d       = st8_ff.d;
      st9_in.num_neg = st8_ff.num_neg;
      st9_in.num_mag = st8_ff.num_mag;
      st9_in.s_zero  = st8_ff.s_zero;
      st9_in.m       = st8_ff.m;
      st9_in.tl      = st8_ff.tl;
      st9_in.p       = st8_ff.p;
   end

   always_comb begin
      dv_side_in.neg     = st9_ff.neg;
      dv_side_in.num_neg = st9_ff.num_neg;
      dv_side_in.s_zero  = st9_ff.s_zero;
      dv_side_in.tl      = st9_ff.tl;
      dv_side_in.p       = st9_ff.p;
   end

   // energy divider carries the side data for all four
   lbfv_rdiv #(
      .NUMW   (TW),
      .DENW   (DW),
      .SIDE_W ($bits(dv_side_type))
   ) u_div_e (
      .clock     (clock),
      .reset     (reset),
      .step_in   (dv_step),
      .num_in    (TW'(st9_ff.num_mag)),
      .den_in    (DW'(st9_ff.m)),
      .side_in   (dv_side_in),
      .valid_out (dv_valid),
      .quo_out   (q_e),
      .side_out  (dv_side)
   );

   for (genvar gi = 0; gi < 3; gi++) begin : g_div_p
      lbfv_rdiv #(
         .NUMW   (TW),
         .DENW   (DW),
         .SIDE_W (1)
      ) u_div_p (
         .clock     (clock),
         .reset     (reset),
         .step_in   (dv_step),
         .num_in    (st9_ff.t[gi]),
         .den_in    (st9_ff.d),
         .side_in   (1'b0),
         .valid_out (),
         .quo_out   (q_p[gi]),
         .side_out  ()
      );
   end

   // apply signs, add the particle momentum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_side.s_zero) begin
            st10_in.v[i] = VW'($signed(dv_side.p[i]));
         end else if (dv_side.neg[i]) begin
            st10_in.v[i] = VW'($signed(dv_side.p[i])) - VW'(q_p[i]);
         end else begin
            st10_in.v[i] = VW'($signed(dv_side.p[i])) + VW'(q_p[i]);
         end
      end
      st10_in.ve = dv_side.num_neg ? -VW'(q_e) : VW'(q_e);
      st10_in.tl = dv_side.tl;
   end

   logic [3:0][VW-1:0] fin_val;
   logic [3:0][W-1:0]  fin_word;
   logic [3:0]         fin_clip;

   assign fin_val = {st10_ff.ve, st10_ff.v[2], st10_ff.v[1], st10_ff.v[0]};

   // saturate to the field range
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if ($signed(fin_val[i]) > VMAX) begin
            fin_word[i] = WMAX;
            fin_clip[i] = 1'b1;
         end else if ($signed(fin_val[i]) < VMIN) begin
            fin_word[i] = WMIN;
            fin_clip[i] = 1'b1;
         end else begin
            fin_word[i] = fin_val[i][W-1:0];
            fin_clip[i] = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in.px  = st10_ff.tl ? fin_word[0] : '0;
      rsp_in.py  = st10_ff.tl ? fin_word[1] : '0;
      rsp_in.pz  = st10_ff.tl ? fin_word[2] : '0;
      rsp_in.e   = st10_ff.tl ? fin_word[3] : '0;
      rsp_in.nt  = !st10_ff.tl;
      rsp_in.sat = st10_ff.tl && (|fin_clip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= sq_valid;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         v10_ff       <= dv_valid;
         rsp_valid_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff  <= st1_in;
         st2_ff  <= st2_in;
         st3_ff  <= st3_in;
         st4_ff  <= st4_in;
         st5_ff  <= st5_in;
         st6_ff  <= st6_in;
         st7_ff  <= st7_in;
         st8_ff  <= st8_in;
         st9_ff  <= st9_in;
         st10_ff <= st10_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_px       = rsp_ff.px;
   assign rsp_out_py       = rsp_ff.py;
   assign rsp_out_pz       = rsp_ff.pz;
   assign rsp_out_e        = rsp_ff.e;
   assign rsp_not_timelike = rsp_ff.nt;
   assign rsp_saturated    = rsp_ff.sat;

   // a boost that is not timelike leaves zeroed values and no clipping
   `LBFV_ASSERT_IMPL(a_nt_zero, clock, reset, rsp_valid && rsp_not_timelike, rsp_out_px == '0 && rsp_out_py == '0 && rsp_out_pz == '0 && rsp_out_e == '0 && !rsp_saturated)

   // clipping leaves at least one value at a range bound
   `LBFV_ASSERT_IMPL(a_sat_bound, clock, reset, rsp_valid && rsp_saturated, rsp_out_px == WMAX || rsp_out_px == WMIN || rsp_out_py == WMAX || rsp_out_py == WMIN || rsp_out_pz == WMAX || rsp_out_pz == WMIN || rsp_out_e == WMAX || rsp_out_e == WMIN)

   // reset empties the output stage
   `LBFV_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

>>> test/lorentz_boost_four_vector_tb.sv
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector_tb
// Streams directed and random particle/boost four-vector pairs through the
// boost pipeline under random idling on both sides. Each result transaction
// is checked field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vector_tb;
   import lbfv_pkg::*;

   localparam int W           = 32;
   localparam int N_RANDOM    = 1750;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_WAIT  = 300;

   typedef logic signed [127:0] s128_t;

   typedef struct {
      logic signed [W-1:0] px, py, pz, e;
      logic signed [W-1:0] ax, ay, az, ae;
      bit                  drain;   // hold until all results are back
   } boost_item_t;

   typedef struct packed {
      logic signed [W-1:0] px, py, pz, e;
      logic                not_timelike;
      logic                saturated;
   } boost_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [W-1:0] req_part_px = '0, req_part_py = '0, req_part_pz = '0;
   logic signed [W-1:0] req_part_e = '0;
   logic signed [W-1:0] req_boost_px = '0, req_boost_py = '0, req_boost_pz = '0;
   logic signed [W-1:0] req_boost_e = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_out_px, rsp_out_py, rsp_out_pz, rsp_out_e;
   logic rsp_not_timelike, rsp_saturated;

   boost_item_t   pending_items[$];
   boost_item_t   cur_item;
   boost_result_t expected_results[$];
   int            error_count = 0;
   int            cycle_count = 0;
   int            send_gap = 0;
   int            recv_gap = 0;
   bit            no_idle = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lorentz_boost_four_vector #(.COMP_WIDTH(W)) i_dut (.*);

   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] res, bit_v;
      res   = '0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n   = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // nearest, ties away from zero; den nonzero
   function automatic s128_t round_div(s128_t num, s128_t den);
      logic [127:0] nm, dm, q, r;
      nm = num < 0 ? -num : num;
      dm = den < 0 ? -den : den;
      q  = nm / dm;
      r  = nm % dm;
      if (r >= dm - r) q = q + 1;
      return ((num < 0) != (den < 0)) ? -s128_t'(q) : s128_t'(q);
   endfunction

   function automatic logic signed [W-1:0] clip_w(s128_t v, ref logic sat);
      s128_t hi, lo;
      hi = (s128_t'(1) <<< (W - 1)) - 1;
      lo = -(s128_t'(1) <<< (W - 1));
      if (v > hi) begin
         sat = 1'b1;
         return hi[W-1:0];
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo[W-1:0];
      end
      return v[W-1:0];
   endfunction

   function automatic boost_result_t boost_predict(boost_item_t it);
      boost_result_t res;
      s128_t p[3], a[3], e, ae, asq, m2, dot, s, nn, m;
      logic sat;
      p[0] = it.px; p[1] = it.py; p[2] = it.pz;
      a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
      e    = it.e;
      ae   = it.ae;
      res  = '0;
      sat  = 1'b0;
      asq  = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      m2   = ae * ae - asq;
      if (m2 <= 0) begin
         res.not_timelike = 1'b1;
         return res;
      end
      m     = s128_t'({64'd0, floor_sqrt(m2[63:0])});
      dot   = p[0] * a[0] + p[1] * a[1] + p[2] * a[2];
      res.e = clip_w(round_div(e * ae - dot, m), sat);
      s     = ae + m;
      nn    = dot - e * s;
      res.px = clip_w(p[0] + (s != 0 ? round_div(nn * a[0], s * m) : 0), sat);
      res.py = clip_w(p[1] + (s != 0 ? round_div(nn * a[1], s * m) : 0), sat);
      res.pz = clip_w(p[2] + (s != 0 ? round_div(nn * a[2], s * m) : 0), sat);
      res.saturated = sat;
      return res;
   endfunction

   function automatic logic signed [W-1:0] rand_scaled();
      logic signed [W-1:0] v;
      v = $urandom;
      return v >>> $urandom_range(0, 31);
   endfunction

   // magnitude of a field, widened so the most negative code is exact
   function automatic logic [W+1:0] abs_w(logic signed [W-1:0] v);
      logic signed [W+1:0] x;
      x = (W+2)'(v);
      return x < 0 ? -x : x;
   endfunction

   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic add_item(logic signed [W-1:0] px, py, pz, e, ax, ay, az, ae,
                           bit drain = 1'b0);
      boost_item_t it;
      it = '{px, py, pz, e, ax, ay, az, ae, drain};
      pending_items.push_back(it);
   endtask

   task automatic add_random_item(int idx);
      boost_item_t it;
      logic [W+1:0] norm1;
      int kind;
      kind = $urandom_range(0, 9);
      it.drain = (idx == 400) || ($urandom_range(0, 199) == 0);
      if (kind < 2) begin
         // raw full-range fields, mostly spacelike
         it.px = $urandom; it.py = $urandom; it.pz = $urandom; it.e = $urandom;
         it.ax = $urandom; it.ay = $urandom; it.az = $urandom; it.ae = $urandom;
      end else begin
         it.px = rand_scaled(); it.py = rand_scaled();
         it.pz = rand_scaled(); it.e  = rand_scaled();
         it.ax = rand_scaled(); it.ay = rand_scaled(); it.az = rand_scaled();
         // energy above the L1 norm keeps the boost timelike (kind 9 and the clip can break this)
         norm1 = abs_w(it.ax) + abs_w(it.ay) + abs_w(it.az)
               + (W+2)'($urandom_range(1, 1000));
         if (kind == 9) norm1 = $urandom_range(0, 3);
         if (norm1 > 32'h7fff_ffff) norm1 = 32'h7fff_ffff;
         it.ae = $urandom_range(0, 1) ? -$signed(norm1[W-1:0]) : $signed(norm1[W-1:0]);
      end
      pending_items.push_back(it);
   endtask

   // transaction driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_results.push_back(boost_predict(cur_item));
         if ($urandom_range(0, 299) == 0) no_idle <= !no_idle;
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      !(pending_items[0].drain &&
                        (req_valid || expected_results.size() != 0))) begin
            cur_item = pending_items.pop_front();
            req_part_px  <= cur_item.px;
            req_part_py  <= cur_item.py;
            req_part_pz  <= cur_item.pz;
            req_part_e   <= cur_item.e;
            req_boost_px <= cur_item.ax;
            req_boost_py <= cur_item.ay;
            req_boost_pz <= cur_item.az;
            req_boost_e  <= cur_item.ae;
            req_valid    <= 1'b1;
            send_gap     <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      boost_result_t got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_px, rsp_out_py, rsp_out_pz, rsp_out_e,
                    rsp_not_timelike, rsp_saturated};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result transaction, actual %p", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  $display({"%0t: mismatch px exp %0d act %0d, py exp %0d act %0d, ",
                            "pz exp %0d act %0d, e exp %0d act %0d, ",
                            "ntl exp %0b act %0b, sat exp %0b act %0b"},
                           $time, want.px, got.px, want.py, got.py, want.pz, got.pz,
                           want.e, got.e, want.not_timelike, got.not_timelike,
                           want.saturated, got.saturated);
                  error_count <= error_count + 1;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap  <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   localparam logic signed [W-1:0] MAXV = 32'sh7fff_ffff;
   localparam logic signed [W-1:0] MINV = 32'sh8000_0000;

   initial begin
      // directed: null, lightlike, spacelike, rest frame, zero denominator,
      // extremes, saturation
      add_item(0, 0, 0, 0, 0, 0, 0, 0);
      add_item(5, 6, 7, 8, 3, 0, 0, 3);
      add_item(5, 6, 7, 8, 3, 4, 0, -5);
      add_item(1, 2, 3, 4, 10, 0, 0, 1);
      add_item(100, -200, 300, 4096, 0, 0, 0, 4096);
      add_item(100, -200, 300, 4096, 0, 0, 0, -4096);
      add_item(MAXV, MINV, MAXV, MINV, 0, 0, 0, MINV);
      add_item(MAXV, MAXV, MAXV, MAXV, 0, 0, 0, MAXV);
      add_item(MINV, MINV, MINV, MINV, 0, 0, 0, 1);
      add_item(MAXV, MAXV, MAXV, MAXV, 1, 1, 1, 2);
      add_item(MINV, MINV, MINV, MINV, -1, -1, -1, -2);
      add_item(MAXV, 0, 0, MINV, 32'sh4000_0000, 0, 0, MAXV);
      add_item(MINV, MAXV, MINV, MAXV, 32'sh7fff_fffe, 0, 0, MAXV, 1'b1);
      add_item(MAXV, MINV, MAXV, MINV, MINV, MINV, MINV, MINV);
      add_item(-1, -1, -1, -1, -1, -1, -1, -1);
      add_item(1000, 2000, -3000, 50000, 100, -200, 300, MINV);
      add_item(4096, 0, 0, 8192, 2048, 2048, 2048, 4096);
      for (int i = 0; i < N_RANDOM; i++) add_random_item(i);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
